// ----- rtl/core/point_light_grid_accumulator_assert.svh -----
// ----------------------------------------------------------------------------
// Point light grid accumulator assertion macros
// Concurrent assertion helpers, included by the controller of the block.
// ----------------------------------------------------------------------------
`ifndef POINT_LIGHT_GRID_ACCUMULATOR_ASSERT_SVH
`define POINT_LIGHT_GRID_ACCUMULATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every rising clock edge outside reset.
`define PLGA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that, once seen, forces a consequence in the next cycle.
`define PLGA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PLGA_ASSERT(name, clk, rst_n, prop, msg)
`define PLGA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/plga_pkg.sv -----
// ----------------------------------------------------------------------------
// Point light grid accumulator package
// Shared constants, codes and control structures of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plga_pkg;

  // Field widths of the channels and registers.
  localparam int CMD_W    = 2;
  localparam int COORD_W  = 16;
  localparam int BRIGHT_W = 16;
  localparam int CIDX_W   = 10;
  localparam int VALUE_W  = 16;
  localparam int LIT_W    = 5;
  localparam int AREA_W   = 5;
  localparam int CENTER_W = 15;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Stamp geometry.
  localparam int STAMP   = 5;
  localparam int STAMP_W = 3;
  localparam logic [STAMP_W-1:0] STAMP_LAST = STAMP_W'(STAMP - 1);

  // Distance weighting. The squared distance never exceeds 21 bits.
  localparam int unsigned DIST_NUM = 1088608;
  localparam int DIST_W    = 21;
  localparam int QUO_W     = 22;
  localparam int DIV_STEPS = QUO_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int PROD_W    = BRIGHT_W + QUO_W;
  localparam int INT_SHIFT = 5;
  localparam int CAP       = 32;
  localparam int CAP_W     = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPLY = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } command_e;

  typedef enum logic [1:0] {
    REG_AREA_WIDTH    = 2'd0,
    REG_AREA_HEIGHT   = 2'd1,
    REG_VIEW_CENTER_X = 2'd2,
    REG_VIEW_CENTER_Z = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [AREA_W-1:0]   area_width;
    logic [AREA_W-1:0]   area_height;
    logic [CENTER_W-1:0] view_center_x;
    logic [CENTER_W-1:0] view_center_z;
  } plga_cfg_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic check;
    logic advance;
    logic square;
    logic div_start;
    logic mult;
    logic write;
    logic read_issue;
    logic read_capture;
    logic clear_write;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic cell_ok;
    logic last_cell;
    logic div_done;
    logic clear_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/plga_if.sv -----
// ----------------------------------------------------------------------------
// Point light grid accumulator channels
// Valid/ready interfaces for the command and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface plga_in_if;
  import plga_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic signed [COORD_W-1:0]  light_x;
  logic signed [COORD_W-1:0]  light_z;
  logic [BRIGHT_W-1:0]        brightness;
  logic [CIDX_W-1:0]          cell_index;

  modport source (output valid, command, light_x, light_z, brightness, cell_index,
                  input ready);
  modport sink (input valid, command, light_x, light_z, brightness, cell_index,
                output ready);
endinterface

interface plga_out_if;
  import plga_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  cell_value;
  logic [LIT_W-1:0]           cells_lit;

  modport source (output valid, cell_value, cells_lit, input ready);
  modport sink (input valid, cell_value, cells_lit, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/plga_div.sv -----
// ----------------------------------------------------------------------------
// Point light grid accumulator divider
// Restoring divider of the distance constant by a squared distance, two
// quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plga_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [plga_pkg::DIST_W-1:0]  divisor_i,
  output logic [plga_pkg::QUO_W-1:0]   quot_o,
  output logic                         done_o
);
  import plga_pkg::*;

  logic [DIST_W-1:0]    div_q;
  logic [DIST_W-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0]     num_q, num_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q;

  always_comb begin
    logic [DIST_W:0] shifted;
    rem_d = rem_q;
    num_d = num_q;
    quo_d = quo_q;
    for (int k = 0; k < 2; k++) begin
      shifted = {rem_d, num_d[QUO_W-1]};
      num_d   = {num_d[QUO_W-2:0], 1'b0};
      if (shifted >= {1'b0, div_q}) begin
        rem_d = DIST_W'(shifted - {1'b0, div_q});
        quo_d = {quo_d[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIST_W-1:0];
        quo_d = {quo_d[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      num_q <= QUO_W'(DIST_NUM);
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q;
  assign done_o = (cnt_q == '0);

endmodule

`default_nettype wire

// ----- rtl/core/plga_dp.sv -----
// ----------------------------------------------------------------------------
// Point light grid accumulator datapath
// Light geometry, grid memory, distance weighting and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plga_dp #(
  parameter int AREA_MAX = 31,
  parameter int MAP_COLS = 128,
  parameter int MAP_ROWS = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  plga_pkg::plga_cfg_t                  cfg_i,
  input  plga_pkg::dp_cmd_t                    cmd_i,
  output plga_pkg::dp_status_t                 status_o,
  input  logic signed [plga_pkg::COORD_W-1:0]  light_x_i,
  input  logic signed [plga_pkg::COORD_W-1:0]  light_z_i,
  input  logic [plga_pkg::BRIGHT_W-1:0]        brightness_i,
  input  logic [plga_pkg::CIDX_W-1:0]          cell_index_i,
  output logic signed [plga_pkg::VALUE_W-1:0]  cell_value_o,
  output logic [plga_pkg::LIT_W-1:0]           cells_lit_o
);
  import plga_pkg::*;

  localparam int GRID_DEPTH = (AREA_MAX + 1) * (AREA_MAX + 1);
  localparam int AW         = $clog2(GRID_DEPTH);
  localparam int IW         = (AW > CIDX_W) ? AW + 1 : CIDX_W + 1;
  localparam int SCALED_W   = PROD_W - INT_SHIFT;
  localparam logic [10:0] MAP_COLS_L = 11'(MAP_COLS);
  localparam logic [10:0] MAP_ROWS_L = 11'(MAP_ROWS);

  // Captured item.
  logic signed [COORD_W-1:0] lx_q, lz_q;
  logic [BRIGHT_W-1:0]       b_q;
  logic [CIDX_W-1:0]         cidx_q;

  // Stamp origin and cell counters.
  logic signed [10:0] tx0_q, tz0_q, rx0_q, rz0_q;
  logic [STAMP_W-1:0] i_q, j_q;

  // Per-cell pipeline.
  logic [AW-1:0]      idx_q;
  logic signed [10:0] dx_q, dz_q;
  logic [19:0]        dxsq_q, dzsq_q;
  logic               dist_zero_q;
  logic [PROD_W-1:0]  prod_q;

  // Grid memory and results.
  logic [VALUE_W-1:0] grid_mem [GRID_DEPTH];
  logic [VALUE_W-1:0] rdata_q;
  logic               in_range_q;
  logic [AW-1:0]      clr_addr_q;
  logic [VALUE_W-1:0] value_q, out_value_q;
  logic [LIT_W-1:0]   lit_q, out_lit_q;

  // ---- setup geometry ----
  logic signed [10:0] tx0_w, tz0_w, adj_w, adj_min, rx0_w, rz0_w;
  logic signed [17:0] lx_w, lz_w, cx_lo, cx_hi, cz_lo, cz_hi;
  logic               off_map, off_view;

  assign tx0_w = 11'($signed(lx_q[15:8])) - 11'sd2;
  assign tz0_w = 11'($signed(lz_q[15:8])) - 11'sd2;
  assign lx_w  = 18'(lx_q);
  assign lz_w  = 18'(lz_q);
  assign cx_lo = $signed({3'b000, cfg_i.view_center_x})
               - $signed({6'b000000, cfg_i.area_width, 7'b0000000});
  assign cx_hi = $signed({3'b000, cfg_i.view_center_x})
               + $signed({6'b000000, cfg_i.area_width, 7'b0000000});
  assign cz_lo = $signed({3'b000, cfg_i.view_center_z})
               - $signed({6'b000000, cfg_i.area_height, 7'b0000000});
  assign cz_hi = $signed({3'b000, cfg_i.view_center_z})
               + $signed({6'b000000, cfg_i.area_height, 7'b0000000});

  assign off_map  = (tz0_w <= -11'sd5) || (tz0_w >= $signed(MAP_ROWS_L))
                 || (tx0_w <= -11'sd5) || (tx0_w >= $signed(MAP_COLS_L));
  assign off_view = (lz_w <= cz_lo) || (lz_w >= cz_hi)
                 || (lx_w <= cx_lo) || (lx_w >= cx_hi);

  // The row offset never goes positive, the column offset is taken as is.
  assign adj_w   = $signed({7'b0000000, cfg_i.area_height[4:1]})
                 - $signed({4'b0000, cfg_i.view_center_z[14:8]});
  assign adj_min = (!adj_w[10] && (adj_w != 11'sd0)) ? 11'sd0 : adj_w;
  assign rz0_w   = adj_min + tz0_w;
  assign rx0_w   = $signed({7'b0000000, cfg_i.area_width[4:1]})
                 - $signed({4'b0000, cfg_i.view_center_x[14:8]}) + tx0_w;

  // ---- per-cell check ----
  logic signed [10:0] tx, tz, rx, rz;
  logic               rx_ok, rz_ok, tx_ok, tz_ok, store_ok;
  logic [IW-1:0]      idx_full;
  logic signed [17:0] dx_w, dz_w;

  assign tx = tx0_q + $signed({8'b00000000, i_q});
  assign rx = rx0_q + $signed({8'b00000000, i_q});
  assign tz = tz0_q + $signed({8'b00000000, j_q});
  assign rz = rz0_q + $signed({8'b00000000, j_q});

  assign rx_ok = !rx[10] && (rx[9:0] < 10'(cfg_i.area_width));
  assign rz_ok = !rz[10] && (rz[9:0] < 10'(cfg_i.area_height));
  assign tx_ok = !tx[10] && ($unsigned(tx) < MAP_COLS_L);
  assign tz_ok = !tz[10] && ($unsigned(tz) < MAP_ROWS_L);

  assign idx_full = IW'(rx[4:0]) + IW'(cfg_i.area_width) * IW'(rz[4:0]);
  assign store_ok = idx_full < IW'(GRID_DEPTH);

  assign dx_w = $signed({3'b000, tx[6:0], 8'h00}) - lx_w;
  assign dz_w = $signed({3'b000, tz[6:0], 8'h00}) - lz_w;

  // ---- weighting ----
  logic signed [21:0]   dx_prod, dz_prod;
  logic [DIST_W-1:0]    dist_w;
  logic [QUO_W-1:0]     quot;
  logic                 div_done;
  logic [QUO_W-1:0]     f_w;
  logic [PROD_W-1:0]    prod_w;
  logic [SCALED_W-1:0]  scaled;
  logic [CAP_W-1:0]     inten;
  logic [VALUE_W-1:0]   sum_w;

  assign dx_prod = dx_q * dx_q;
  assign dz_prod = dz_q * dz_q;
  assign dist_w  = DIST_W'({1'b0, dxsq_q} + {1'b0, dzsq_q});

  plga_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .divisor_i (dist_w),
    .quot_o    (quot),
    .done_o    (div_done)
  );

  assign f_w    = dist_zero_q ? QUO_W'(CAP) : quot;
  assign prod_w = b_q * f_w;
  assign scaled = prod_q[PROD_W-1:INT_SHIFT];
  assign inten  = (scaled > SCALED_W'(CAP)) ? CAP_W'(CAP) : scaled[CAP_W-1:0];
  assign sum_w  = rdata_q + VALUE_W'(inten);

  // ---- memory ports ----
  logic [IW-1:0]      cidx_full;
  logic               mem_we, mem_re;
  logic [AW-1:0]      waddr, raddr;
  logic [VALUE_W-1:0] wdata;

  assign cidx_full = IW'(cidx_q);
  assign mem_we = cmd_i.clear_write || cmd_i.write;
  assign waddr  = cmd_i.clear_write ? clr_addr_q : idx_q;
  assign wdata  = cmd_i.clear_write ? '0 : sum_w;
  assign mem_re = cmd_i.read_issue || cmd_i.square;
  assign raddr  = cmd_i.read_issue ? cidx_full[AW-1:0] : idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= grid_mem[raddr];
    end
  end

  // ---- control counters ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
    end else begin
      if (cmd_i.clear_write) begin
        clr_addr_q <= status_o.clear_last ? '0 : clr_addr_q + AW'(1);
      end
      if (cmd_i.setup) begin
        i_q <= '0;
        j_q <= '0;
      end else if (cmd_i.advance) begin
        if (i_q == STAMP_LAST) begin
          i_q <= '0;
          j_q <= j_q + STAMP_W'(1);
        end else begin
          i_q <= i_q + STAMP_W'(1);
        end
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lx_q    <= light_x_i;
      lz_q    <= light_z_i;
      b_q     <= brightness_i;
      cidx_q  <= cell_index_i;
      value_q <= '0;
      lit_q   <= '0;
    end
    if (cmd_i.setup) begin
      tx0_q <= tx0_w;
      tz0_q <= tz0_w;
      rx0_q <= rx0_w;
      rz0_q <= rz0_w;
    end
    if (cmd_i.check) begin
      idx_q <= idx_full[AW-1:0];
      dx_q  <= $signed(dx_w[10:0]);
      dz_q  <= $signed(dz_w[10:0]);
    end
    if (cmd_i.square) begin
      dxsq_q <= dx_prod[19:0];
      dzsq_q <= dz_prod[19:0];
    end
    if (cmd_i.div_start) begin
      dist_zero_q <= (dist_w == '0);
    end
    if (cmd_i.mult) begin
      prod_q <= prod_w;
    end
    if (cmd_i.write) begin
      lit_q <= lit_q + LIT_W'(1);
    end
    if (cmd_i.read_issue) begin
      in_range_q <= cidx_full < IW'(GRID_DEPTH);
    end
    if (cmd_i.read_capture) begin
      value_q <= in_range_q ? rdata_q : '0;
    end
    if (cmd_i.load_result) begin
      out_value_q <= value_q;
      out_lit_q   <= lit_q;
    end
  end

  assign status_o.reject     = off_map || off_view;
  assign status_o.cell_ok    = rx_ok && rz_ok && tx_ok && tz_ok && store_ok;
  assign status_o.last_cell  = (i_q == STAMP_LAST) && (j_q == STAMP_LAST);
  assign status_o.div_done   = div_done;
  assign status_o.clear_last = (clr_addr_q == AW'(GRID_DEPTH - 1));

  assign cell_value_o = $signed(out_value_q);
  assign cells_lit_o  = out_lit_q;

endmodule

`default_nettype wire

// ----- rtl/core/plga_ctrl.sv -----
// ----------------------------------------------------------------------------
// Point light grid accumulator controller
// Sequences the clearing sweep, cell reads and the per-cell light stamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "point_light_grid_accumulator_assert.svh"

module plga_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [plga_pkg::CMD_W-1:0]   in_cmd_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output plga_pkg::dp_cmd_t            cmd_o,
  input  plga_pkg::dp_status_t         status_i
);
  import plga_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_CHECK,
    ST_SQUARE,
    ST_DIV_START,
    ST_DIVIDE,
    ST_MULT,
    ST_WRITE,
    ST_READ_ISSUE,
    ST_READ_CAPTURE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   reply_q, reply_d;

  always_comb begin
    state_d     = state_q;
    reply_d     = reply_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = (state_q == ST_IDLE);
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_write = 1'b1;
        if (status_i.clear_last) begin
          // The sweep after reset answers nobody; a clear command does.
          state_d = reply_q ? ST_FINISH : ST_IDLE;
          reply_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (command_e'(in_cmd_i))
            CMD_APPLY: state_d = ST_SETUP;
            CMD_CLEAR: begin
              state_d = ST_CLEAR;
              reply_d = 1'b1;
            end
            CMD_READ:  state_d = ST_READ_ISSUE;
            default:   state_d = ST_FINISH;
          endcase
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = status_i.reject ? ST_FINISH : ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.cell_ok) begin
          state_d = ST_SQUARE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d = status_i.last_cell ? ST_FINISH : ST_CHECK;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write   = 1'b1;
        cmd_o.advance = 1'b1;
        state_d = status_i.last_cell ? ST_FINISH : ST_CHECK;
      end
      ST_READ_ISSUE: begin
        cmd_o.read_issue = 1'b1;
        state_d = ST_READ_CAPTURE;
      end
      ST_READ_CAPTURE: begin
        cmd_o.read_capture = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      reply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      reply_q     <= reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PLGA_ASSERT(a_no_overwrite, clk_i, rst_ni, !(cmd_o.load_result && out_valid_q && !out_ready_i), "result register overwritten before transfer")
  `PLGA_ASSERT_NEXT(a_div_busy, clk_i, rst_ni, cmd_o.div_start, !status_i.div_done, "divider reports done right after start")
  `PLGA_ASSERT(a_write_after_mult, clk_i, rst_ni, !cmd_o.write || $past(cmd_o.mult), "grid write without a weighted product")
  `PLGA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, cmd_o.capture, !in_ready_o, "new item taken while one is in work")

endmodule

`default_nettype wire

// ----- rtl/core/point_light_grid_accumulator.sv -----
// ----------------------------------------------------------------------------
// Point light grid accumulator
// Grid of 16-bit light sums over the visible map window, stamped by lights.
// ----------------------------------------------------------------------------
// Usage: commands arrive on in_ch_i, one transfer per item, and every command
// gives exactly one transfer on out_ch_o. Apply stamps a 5x5 tile area around
// a light, clear zeroes the grid and read returns one cell. The four window
// registers sit on the APB port at byte addresses 0, 4, 8 and 12; the user
// must see that they are written only while the block is idle; the block
// itself does not enforce this. Sequence: a read passes through read-issue
// and read-capture states before its result is loaded, a clear sweeps every
// grid cell and the unused code goes straight to the result. An apply sets
// up the stamp and, unless the light is rejected, checks each stamp cell and
// squares, divides, multiplies and writes each updated cell. Each updated
// cell is bound by one shared divider retiring two quotient bits per cycle.
// One item is worked at a time; the next item is taken once the result is in
// the output register, even while that result still waits for the receiver.
// Reset: the grid memory is swept to zero, one cell per cycle, over the grid
// depth before the first item is taken; register writes are accepted during
// the sweep.
// Stall: a result held by the receiver blocks only the completion of the
// following item, never its acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_light_grid_accumulator #(
  parameter int AREA_MAX = 31,
  parameter int MAP_COLS = 128,
  parameter int MAP_ROWS = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  plga_in_if.sink                        in_ch_i,
  plga_out_if.source                     out_ch_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [plga_pkg::PADDR_W-1:0]   paddr,
  input  logic [plga_pkg::PDATA_W-1:0]   pwdata,
  output logic [plga_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import plga_pkg::*;

  // Window registers. View window and grid row stride both come from these;
  // the user changes them only between items; the block does not enforce it.
  plga_cfg_t  cfg_q;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       cfg_write;
  reg_index_e reg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = reg_index_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.area_width    <= AREA_W'(31);
      cfg_q.area_height   <= AREA_W'(30);
      cfg_q.view_center_x <= CENTER_W'(16384);
      cfg_q.view_center_z <= CENTER_W'(16384);
    end else if (cfg_write) begin
      case (reg_index)
        REG_AREA_WIDTH:    cfg_q.area_width    <= pwdata[AREA_W-1:0];
        REG_AREA_HEIGHT:   cfg_q.area_height   <= pwdata[AREA_W-1:0];
        REG_VIEW_CENTER_X: cfg_q.view_center_x <= pwdata[CENTER_W-1:0];
        REG_VIEW_CENTER_Z: cfg_q.view_center_z <= pwdata[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back, zero extended to the bus width.
  always_comb begin
    case (reg_index)
      REG_AREA_WIDTH:    prdata = PDATA_W'(cfg_q.area_width);
      REG_AREA_HEIGHT:   prdata = PDATA_W'(cfg_q.area_height);
      REG_VIEW_CENTER_X: prdata = PDATA_W'(cfg_q.view_center_x);
      REG_VIEW_CENTER_Z: prdata = PDATA_W'(cfg_q.view_center_z);
      default:           prdata = '0;
    endcase
  end

  // The controller sees only the handshakes and the command code; every
  // payload bit stays in the datapath.
  plga_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_cmd_i    (in_ch_i.command),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  plga_dp #(
    .AREA_MAX (AREA_MAX),
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .light_x_i    (in_ch_i.light_x),
    .light_z_i    (in_ch_i.light_z),
    .brightness_i (in_ch_i.brightness),
    .cell_index_i (in_ch_i.cell_index),
    .cell_value_o (out_ch_o.cell_value),
    .cells_lit_o  (out_ch_o.cells_lit)
  );

endmodule

`default_nettype wire

// ----- bench/point_light_grid_accumulator_test.sv -----
// ----------------------------------------------------------------------------
// Point light grid accumulator testbench
// Drives light, clear, read and unused commands into the block over its
// command channel, predicts every result with a software copy of the light
// grid, and compares each result transfer field by field. The window
// registers are rewritten over the APB port between phases and read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_light_grid_accumulator_test;
  import plga_pkg::*;

  // Geometry of the default build: (AREA_MAX+1)^2 cells over a 128x128 map.
  localparam int GRID_DEPTH = 1024;
  localparam int MAP_COLS   = 128;
  localparam int MAP_ROWS   = 128;

  // Command code 3 has no operation behind it and must answer with zeros.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 8;
  // The slowest command is a clear of the whole grid; with receiver stalls,
  // sender gaps and the long hold-off, 1500 commands stay well under this.
  localparam int CYCLE_LIMIT = 6_000_000;
  // Long enough that the block finishes one command, takes the next and then
  // has to refuse the third.
  localparam int LONG_HOLD = 800;
  // Quiet time at the end, longer than a full clear.
  localparam int END_SETTLE = 1100;

  typedef struct packed {
    logic [CMD_W-1:0]           command;
    logic signed [COORD_W-1:0]  light_x;
    logic signed [COORD_W-1:0]  light_z;
    logic [BRIGHT_W-1:0]        brightness;
    logic [CIDX_W-1:0]          cell_index;
  } light_cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  cell_value;
    logic [LIT_W-1:0]           cells_lit;
  } grid_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  plga_in_if  cmd_ch ();
  plga_out_if res_ch ();

  // Every input of the block comes from one of these variables, so all of
  // them hold a known value from time zero.
  logic                 cmd_valid_q = 1'b0;
  light_cmd_t           cmd_q = '0;
  logic                 res_ready_q = 1'b0;
  logic                 apb_sel = 1'b0;
  logic                 apb_enable = 1'b0;
  logic                 apb_write = 1'b0;
  logic [PADDR_W-1:0]   apb_addr = '0;
  logic [PDATA_W-1:0]   apb_wdata = '0;
  logic [PDATA_W-1:0]   apb_rdata;
  logic                 apb_ready;

  assign cmd_ch.valid      = cmd_valid_q;
  assign cmd_ch.command    = cmd_q.command;
  assign cmd_ch.light_x    = cmd_q.light_x;
  assign cmd_ch.light_z    = cmd_q.light_z;
  assign cmd_ch.brightness = cmd_q.brightness;
  assign cmd_ch.cell_index = cmd_q.cell_index;
  assign res_ch.ready      = res_ready_q;

  point_light_grid_accumulator uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (cmd_ch),
    .out_ch_o (res_ch),
    .psel     (apb_sel),
    .penable  (apb_enable),
    .pwrite   (apb_write),
    .paddr    (apb_addr),
    .pwdata   (apb_wdata),
    .prdata   (apb_rdata),
    .pready   (apb_ready)
  );

  // --------------------------------------------------------------------------
  // Grid predictor
  // --------------------------------------------------------------------------
  // Our own copy of the light grid and of the four window registers. They
  // start in the reset state and the registers change only when the bench
  // writes them over APB.
  logic [VALUE_W-1:0] grid_copy [GRID_DEPTH];
  int win_width  = 31;
  int win_height = 30;
  int center_x   = 16384;
  int center_z   = 16384;

  // Works out the one result that a command gives and updates the grid copy.
  function automatic grid_result_t grid_step(input light_cmd_t c);
    grid_result_t r;
    int lx, lz, tx0, tz0, hx, hz, rx0, rz0, adj;
    int tx, tz, rx, rz, idx, lit, i, j;
    longint dx, dz, dsq, quo, gain;
    bit accept;
    r = '0;
    lit = 0;
    case (c.command)
      CMD_APPLY: begin
        lx = int'($signed(c.light_x));
        lz = int'($signed(c.light_z));
        // Arithmetic shift gives floor(coord / 256) for negative coordinates.
        tx0 = (lx >>> 8) - STAMP / 2;
        tz0 = (lz >>> 8) - STAMP / 2;
        hx = win_width * 128;
        hz = win_height * 128;
        // A light is dropped when its stamp is wholly off the map or when it
        // is not strictly inside the view window around the camera centre.
        accept = !(tz0 <= -STAMP || tz0 >= MAP_ROWS || tx0 <= -STAMP || tx0 >= MAP_COLS ||
                   lz <= center_z - hz || lz >= center_z + hz ||
                   lx <= center_x - hx || lx >= center_x + hx);
        if (accept) begin
          // The z offset is clamped to zero or below, the x offset is not.
          adj = (win_height >>> 1) - (center_z >>> 8);
          if (adj > 0) adj = 0;
          rz0 = adj + tz0;
          rx0 = (win_width >>> 1) - (center_x >>> 8) + tx0;
          for (j = 0; j < STAMP; j++) begin
            for (i = 0; i < STAMP; i++) begin
              tx = tx0 + i;
              tz = tz0 + j;
              rx = rx0 + i;
              rz = rz0 + j;
              if (rx >= 0 && rx < win_width && rz >= 0 && rz < win_height &&
                  tx >= 0 && tx < MAP_COLS && tz >= 0 && tz < MAP_ROWS) begin
                idx = rx + win_width * rz;
                if (idx < GRID_DEPTH) begin
                  dx = longint'(tx) * 256 - lx;
                  dz = longint'(tz) * 256 - lz;
                  dsq = dx * dx + dz * dz;
                  // A light exactly on the tile corner takes the cap as its distance factor.
                  quo = (dsq != 0) ? longint'(DIST_NUM) / dsq : longint'(CAP);
                  gain = (longint'(c.brightness) * quo) >>> INT_SHIFT;
                  if (gain > CAP) gain = CAP;
                  grid_copy[idx] = grid_copy[idx] + VALUE_W'(gain);
                  lit++;
                end
              end
            end
          end
        end
        r.cells_lit = LIT_W'(lit);
      end
      CMD_CLEAR: begin
        for (i = 0; i < GRID_DEPTH; i++) grid_copy[i] = '0;
      end
      CMD_READ: begin
        if (c.cell_index < GRID_DEPTH) r.cell_value = grid_copy[c.cell_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Bookkeeping shared by the processes
  // --------------------------------------------------------------------------
  light_cmd_t   pending_cmds [$];
  grid_result_t expected_results [$];
  bit           cmd_busy = 1'b0;
  logic         cmd_taken = 1'b0;
  int           fail_count = 0;
  int           result_count = 0;
  int           apply_count = 0, lit_total = 0, read_count = 0;
  int           clear_count = 0, unused_count = 0, settings_count = 0;
  int           negative_reads = 0;
  int           rx_mode = 1;
  int           hold_requests = 0;
  int           hold_served = 0;
  longint       cycle_count = 0;

  // --------------------------------------------------------------------------
  // Command driver
  // --------------------------------------------------------------------------
  // Feeds the pending queue into the command channel in bursts of random
  // length with random gaps between them. A command stays on the channel
  // until its transfer has been seen at a rising edge.
  int burst_left = 0;
  int gap_left = 0;
  int gap_pick;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cmd_busy && cmd_taken) cmd_busy = 1'b0;
      if (!cmd_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          cmd_q <= pending_cmds.pop_front();
          cmd_busy = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          burst_left--;
          if (burst_left == 0) begin
            // Mostly back-to-back bursts or short gaps, now and then a long one.
            gap_pick = $urandom_range(0, 9);
            if (gap_pick < 3) gap_left = 0;
            else if (gap_pick < 8) gap_left = $urandom_range(1, 6);
            else gap_left = $urandom_range(20, 80);
          end
        end
      end
      cmd_valid_q <= cmd_busy;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver
  // --------------------------------------------------------------------------
  // Mode 0 always takes results, mode 1 stalls now and then, mode 2 stalls
  // often and for longer. A long hold-off requested by the stimulus is
  // counted down here, whatever the mode.
  int  stall_left = 0;
  logic ready_next;

  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
      case (rx_mode)
        1: if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
        2: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 20);
        default: ;
      endcase
    end
    res_ready_q <= ready_next;
  end

  // --------------------------------------------------------------------------
  // Monitor and checker
  // --------------------------------------------------------------------------
  // At each rising edge a result transfer is checked against the oldest
  // expectation, and a command transfer is run through the predictor.
  always @(posedge clk_i) begin : monitor
    grid_result_t want;
    grid_result_t got;
    cmd_taken <= cmd_ch.valid && cmd_ch.ready;
    if (res_ch.valid && res_ch.ready) begin
      got.cell_value = res_ch.cell_value;
      got.cells_lit  = res_ch.cells_lit;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no command waiting: cell_value %0d cells_lit %0d",
                 $time, got.cell_value, got.cells_lit);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.cell_value !== want.cell_value) begin
          $display("%0t: result %0d cell_value expected %0d actual %0d",
                   $time, result_count, want.cell_value, got.cell_value);
          fail_count++;
        end
        if (got.cells_lit !== want.cells_lit) begin
          $display("%0t: result %0d cells_lit expected %0d actual %0d",
                   $time, result_count, want.cells_lit, got.cells_lit);
          fail_count++;
        end
        if (want.cell_value < 0) negative_reads++;
      end
      result_count++;
    end
    if (cmd_ch.valid && cmd_ch.ready) begin
      want = grid_step(cmd_q);
      expected_results.push_back(want);
      case (cmd_q.command)
        CMD_APPLY: begin
          apply_count++;
          lit_total += want.cells_lit;
        end
        CMD_CLEAR: clear_count++;
        CMD_READ:  read_count++;
        default:   unused_count++;
      endcase
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d results still expected",
               $time, cycle_count, expected_results.size());
      $display("point_light_grid_accumulator_test NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return COORD_W'(v);
  endfunction

  task automatic push_cmd(input logic [CMD_W-1:0] command, input int lx, input int lz,
                          input int bright, input int idx);
    light_cmd_t c;
    c.command    = command;
    c.light_x    = clamp_coord(lx);
    c.light_z    = clamp_coord(lz);
    c.brightness = BRIGHT_W'(bright);
    c.cell_index = CIDX_W'(idx);
    pending_cmds.push_back(c);
  endtask

  // Holds the sender back until every queued command has been answered.
  task automatic drain();
    while (pending_cmds.size() != 0 || cmd_busy || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // One APB write followed by a read of the same register. Each register
  // keeps only its low bits, so only those are compared on read back.
  task automatic reg_write_check(input reg_index_e idx, input int unsigned value);
    logic [PDATA_W-1:0] mask;
    mask = (idx == REG_AREA_WIDTH || idx == REG_AREA_HEIGHT) ? 32'h1f : 32'h7fff;
    @(negedge clk_i);
    apb_sel   <= 1'b1;
    apb_enable <= 1'b0;
    apb_write <= 1'b1;
    apb_addr  <= PADDR_W'({idx, 2'b00});
    apb_wdata <= value;
    @(negedge clk_i);
    apb_enable <= 1'b1;
    @(posedge clk_i);
    while (!apb_ready) @(posedge clk_i);
    // Straight into the setup cycle of the read back.
    @(negedge clk_i);
    apb_enable <= 1'b0;
    apb_write <= 1'b0;
    @(negedge clk_i);
    apb_enable <= 1'b1;
    @(posedge clk_i);
    while (!apb_ready) @(posedge clk_i);
    if ((apb_rdata & mask) !== (value & mask)) begin
      $display("%0t: register %0d read back expected 0x%0h actual 0x%0h",
               $time, idx, value & mask, apb_rdata & mask);
      fail_count++;
    end
    @(negedge clk_i);
    apb_sel <= 1'b0;
    apb_enable <= 1'b0;
    case (idx)
      REG_AREA_WIDTH:    win_width  = int'(value & mask);
      REG_AREA_HEIGHT:   win_height = int'(value & mask);
      REG_VIEW_CENTER_X: center_x   = int'(value & mask);
      default:           center_z   = int'(value & mask);
    endcase
  endtask

  // A new window setting is only written once the block has gone idle.
  task automatic set_window(input int aw, input int ah, input int cx, input int cz,
                            input int mode);
    drain();
    reg_write_check(REG_AREA_WIDTH, aw);
    reg_write_check(REG_AREA_HEIGHT, ah);
    reg_write_check(REG_VIEW_CENTER_X, cx);
    reg_write_check(REG_VIEW_CENTER_Z, cz);
    rx_mode = mode;
    settings_count++;
  endtask

  // Random commands under the current window. Most are lights placed in or
  // just around the window and reads of cells that can hold light; the rest
  // are lights anywhere, reads of any index, clears and the unused code.
  task automatic random_phase(input int count);
    light_cmd_t c;
    int k, pick, half, cells;
    for (k = 0; k < count; k++) begin
      c.command    = CMD_APPLY;
      c.light_x    = COORD_W'($urandom);
      c.light_z    = COORD_W'($urandom);
      c.brightness = BRIGHT_W'($urandom);
      c.cell_index = CIDX_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        // Two extra units each side so that the strict window edges get hit.
        half = win_width * 128 + 2;
        c.light_x = clamp_coord(center_x + int'($urandom_range(0, 2 * half)) - half);
        half = win_height * 128 + 2;
        c.light_z = clamp_coord(center_z + int'($urandom_range(0, 2 * half)) - half);
        case ($urandom_range(0, 3))
          1: c.brightness = BRIGHT_W'($urandom_range(0, 63));
          2: c.brightness = '1;
          3: c.brightness = BRIGHT_W'($urandom_range(0, 1023));
          default: ;
        endcase
      end else if (pick < 70) begin
        c.command = CMD_APPLY;
      end else if (pick < 90) begin
        c.command = CMD_READ;
        cells = win_width * win_height;
        if (cells > 0) c.cell_index = CIDX_W'($urandom_range(0, cells - 1));
      end else if (pick < 94) begin
        c.command = CMD_READ;
      end else if (pick < 97) begin
        c.command = CMD_CLEAR;
      end else begin
        c.command = CMD_UNUSED;
      end
      pending_cmds.push_back(c);
    end
  endtask

  initial begin : stimulus
    int k, cx, cz;
    for (k = 0; k < GRID_DEPTH; k++) grid_copy[k] = '0;

    // Reset is held for a fixed number of cycles and released at a falling
    // edge; the block then sweeps its grid before it takes any command.
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed commands under the reset window: 31x30 tiles around map
    // centre 16384, whose centre tile lands on cell 480.
    rx_mode = 1;
    push_cmd(CMD_READ, 0, 0, 0, 0);
    push_cmd(CMD_READ, 0, 0, 0, 1023);
    // Light right on a tile corner, so the distance there is zero.
    push_cmd(CMD_APPLY, 16384, 16384, 65535, 0);
    push_cmd(CMD_READ, 0, 0, 0, 480);
    push_cmd(CMD_APPLY, 16512, 16307, 1, 0);
    // Zero brightness still counts the cells it reaches.
    push_cmd(CMD_APPLY, 16400, 16400, 0, 0);
    // Far corners: off the map, and off the window.
    push_cmd(CMD_APPLY, -32768, -32768, 65535, 1023);
    push_cmd(CMD_APPLY, 32767, 32767, 65535, 1023);
    // The window edges are exclusive: one unit in is accepted.
    push_cmd(CMD_APPLY, 16384, 20224, 500, 0);
    push_cmd(CMD_APPLY, 16384, 20223, 500, 0);
    push_cmd(CMD_APPLY, 12416, 16384, 700, 0);
    push_cmd(CMD_APPLY, 12417, 16384, 700, 0);
    push_cmd(CMD_APPLY, 20351, 20223, 300, 0);
    push_cmd(CMD_READ, 0, 0, 0, 481);
    // The unused code must leave the grid alone and answer with zeros.
    push_cmd(CMD_UNUSED, -1, -1, 65535, 1023);
    push_cmd(CMD_READ, 0, 0, 0, 480);
    push_cmd(CMD_CLEAR, 0, 0, 0, 0);
    push_cmd(CMD_READ, 0, 0, 0, 480);
    push_cmd(CMD_APPLY, 16500, 16300, 65535, 0);
    push_cmd(CMD_READ, 0, 0, 0, 480);
    push_cmd(CMD_READ, 0, 0, 0, 511);
    push_cmd(CMD_READ, 0, 0, 0, 929);

    // Widest window at the map origin. The receiver holds off for a long
    // stretch at the start, so the block fills and refuses commands.
    set_window(31, 31, 0, 0, 2);
    hold_requests++;
    random_phase(50);

    // Narrowest non-empty window at the far map corner.
    set_window(1, 1, 32767, 32767, 1);
    random_phase(50);

    // A zero width or a zero height rejects every light.
    set_window(0, 9, $urandom_range(0, 32767), $urandom_range(0, 32767), 0);
    random_phase(15);
    set_window(12, 0, $urandom_range(0, 32767), $urandom_range(0, 32767), 2);
    random_phase(15);

    // One-cell window: every light near the centre adds the full cap to
    // cell 0, so its sum climbs past the sign bit. Reads are sprinkled in.
    cx = $urandom_range(2000, 30000);
    cz = $urandom_range(2000, 30000);
    set_window(1, 1, cx, cz, 1);
    for (k = 0; k < 1120; k++) begin
      if (k % 18 == 17)
        push_cmd(CMD_READ, $urandom, $urandom, $urandom, ($urandom_range(0, 3) == 0) ?
                 $urandom : 0);
      else
        push_cmd(CMD_APPLY, cx + int'($urandom_range(0, 254)) - 127,
                 cz + int'($urandom_range(0, 254)) - 127, $urandom_range(1024, 65535),
                 $urandom);
    end

    // Random windows anywhere on the map.
    for (k = 0; k < 4; k++) begin
      set_window($urandom_range(1, 31), $urandom_range(1, 31), $urandom_range(0, 32767),
                 $urandom_range(0, 32767), k % 3);
      random_phase(50);
    end

    // Everything has been handed to the driver; wait for the last transfer,
    // the last result, and then a quiet stretch in which nothing may appear.
    while (pending_cmds.size() != 0 || cmd_busy) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);

    $display("Covered %0d applies lighting %0d cells, %0d reads (%0d negative), %0d clears,",
             apply_count, lit_total, read_count, negative_reads, clear_count);
    $display("%0d unused-code commands and %0d window settings; %0d mismatches.",
             unused_count, settings_count, fail_count);
    if (fail_count == 0) begin
      $display("point_light_grid_accumulator_test OK");
    end else begin
      $display("point_light_grid_accumulator_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/plga_pkg.sv
rtl/core/plga_if.sv
rtl/core/plga_div.sv
rtl/core/plga_dp.sv
rtl/core/plga_ctrl.sv
rtl/core/point_light_grid_accumulator.sv
bench/point_light_grid_accumulator_test.sv
